>>> design/pga_pkg.sv
`default_nettype none
package pga_pkg;

  localparam int GRID_X_DEF = 256;
  localparam int GRID_Y_DEF = 256;
  localparam int ACC_W      = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_N_WINDOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_M_WINDOW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_SCALE_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_SCALE_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FLUX_SCALE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_SCALE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_NUCLEUS     = 3'd6;

  localparam logic [31:0] SCALE_ONE = 32'h0001_0000;

  typedef enum logic [2:0] {
    MUL_BINX,
    MUL_BINY,
    MUL_RSQ,
    MUL_FSW,
    MUL_DSW,
    MUL_PP
  } mul_sel_t;

  typedef struct packed {
    logic       in_rdy;
    logic       clr_en;
    mul_sel_t   mul_sel;
    logic [1:0] pp_step;
    logic       ld_ix;
    logic       ld_iy;
    logic       ld_r2;
    logic       ld_cell;
    logic       ld_sw;
    logic       acc_en;
    logic [1:0] acc_step;
    logic       ld_term;
    logic       term_sel;
    logic       wr_en;
    logic       ld_out;
  } cmd_t;

  typedef struct packed {
    logic in_acc;
    logic is_read;
    logic chk_ok;
    logic clr_last;
    logic out_free;
  } sts_t;

  // floor of the Q64.64 product to Q32.16, saturated
  function automatic logic [ACC_W-1:0] sat_q(input logic [127:0] p);
    logic [ACC_W-1:0] r;
    if (p[127:96] != 32'd0) begin
      r = {ACC_W{1'b1}};
    end else begin
      r = p[95:48];
    end
    return r;
  endfunction

  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                               input logic [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    logic [ACC_W-1:0] r;
    s = {1'b0, a} + {1'b0, b};
    if (s[ACC_W]) begin
      r = {ACC_W{1'b1}};
    end else begin
      r = s[ACC_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/pga_if.sv
`default_nettype none
interface pga_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [31:0] coord_n;
  logic signed [31:0] coord_m;
  logic               emitted;
  logic        [31:0] radius;
  logic        [31:0] weight;
  logic        [15:0] read_cell;
  logic               last_particle;

  modport source(output valid, operation, coord_n, coord_m, emitted, radius, weight,
                 read_cell, last_particle, input ready);
  modport sink(input valid, operation, coord_n, coord_m, emitted, radius, weight,
               read_cell, last_particle, output ready);
endinterface

interface pga_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [15:0] cell_index;
  logic [47:0] flux_value;
  logic [47:0] depth_value;
  logic [47:0] nucleus_depth;
  logic        batch_done;

  modport source(output valid, accepted, cell_index, flux_value, depth_value,
                 nucleus_depth, batch_done, input ready);
  modport sink(input valid, accepted, cell_index, flux_value, depth_value,
               nucleus_depth, batch_done, output ready);
endinterface
`default_nettype wire

>>> design/particle_grid_accumulator.sv
// particle_grid_accumulator: weighted 2d histogram of particles into two grids
// in_if carries one word per item: accumulate a particle (operation 0) or read
// one grid cell (operation 1); out_if returns exactly one word per item.
// cfg_we/cfg_index/cfg_data write the windows, bin scales, term scales and the
// nucleus cell; write only while the block is idle.
// after reset both grids are swept to zero, one cell per cycle, so the block
// takes no input until the sweep ends; config writes are taken meanwhile.
// one word is in flight at a time: the next word can be taken in the cycle
// after the last one loads its result. the pace is set by the single shared
// 32x32 multiplier, which forms the bins, r^2, scale*w and the four partial
// products of each 64x64 term in turn.
// the result sits in an output register: if the receiver stalls, the next
// word is still accepted and processed, and waits only to load that register.
`default_nettype none
module particle_grid_accumulator #(
  parameter int GRID_X = pga_pkg::GRID_X_DEF,
  parameter int GRID_Y = pga_pkg::GRID_Y_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [pga_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pga_pkg::CFG_DATA_W-1:0] cfg_data,
  pga_in_if.sink                              in_if,
  pga_out_if.source                           out_if
);

  pga_pkg::cmd_t cmd;
  pga_pkg::sts_t sts;

  pga_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  pga_dp #(
    .GRID_X (GRID_X),
    .GRID_Y (GRID_Y)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_if     (in_if),
    .out_if    (out_if),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
`default_nettype wire

>>> design/pga_ctrl.sv
`default_nettype none
module pga_ctrl (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  pga_pkg::sts_t  sts,
  output pga_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_BINX,
    S_BINY,
    S_RSQ,
    S_CHK,
    S_SW,
    S_SWLD,
    S_PP,
    S_PPA,
    S_TERM,
    S_WR,
    S_RDCHK,
    S_RDW,
    S_OUT
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pass_r, pass_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r   <= 2'd0;
      pass_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pass_r  <= pass_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pass_nxt  = pass_r;
    cmd       = '0;
    cmd.mul_sel = pga_pkg::MUL_BINX;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cmd.in_rdy = 1'b1;
        if (sts.in_acc) state_nxt = S_BINX;
      end
      S_BINX: begin
        if (sts.is_read) begin
          state_nxt = S_RDCHK;
        end else begin
          state_nxt = S_BINY;
        end
      end
      S_BINY: begin
        cmd.mul_sel = pga_pkg::MUL_BINY;
        cmd.ld_ix   = 1'b1;
        state_nxt   = S_RSQ;
      end
      S_RSQ: begin
        cmd.mul_sel = pga_pkg::MUL_RSQ;
        cmd.ld_iy   = 1'b1;
        state_nxt   = S_CHK;
      end
      S_CHK: begin
        cmd.ld_r2   = 1'b1;
        cmd.ld_cell = 1'b1;
        pass_nxt    = 1'b0;
        state_nxt   = sts.chk_ok ? S_SW : S_OUT;
      end
      S_SW: begin
        cmd.mul_sel = pass_r ? pga_pkg::MUL_DSW : pga_pkg::MUL_FSW;
        state_nxt   = S_SWLD;
      end
      S_SWLD: begin
        cmd.ld_sw = 1'b1;
        cnt_nxt   = 2'd0;
        state_nxt = S_PP;
      end
      S_PP: begin
        // multiply one partial product, accumulate the previous one
        cmd.mul_sel  = pga_pkg::MUL_PP;
        cmd.pp_step  = cnt_r;
        cmd.acc_en   = (cnt_r != 2'd0);
        cmd.acc_step = cnt_r - 2'd1;
        cnt_nxt      = cnt_r + 2'd1;
        if (cnt_r == 2'd3) state_nxt = S_PPA;
      end
      S_PPA: begin
        cmd.acc_en   = 1'b1;
        cmd.acc_step = 2'd3;
        state_nxt    = S_TERM;
      end
      S_TERM: begin
        cmd.ld_term  = 1'b1;
        cmd.term_sel = pass_r;
        pass_nxt     = 1'b1;
        state_nxt    = pass_r ? S_WR : S_SW;
      end
      S_WR: begin
        cmd.wr_en = 1'b1;
        state_nxt = S_OUT;
      end
      S_RDCHK: begin
        cmd.ld_cell = 1'b1;
        state_nxt   = S_RDW;
      end
      S_RDW: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.ld_out = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> design/pga_dp.sv
`default_nettype none
module pga_dp #(
  parameter int GRID_X = pga_pkg::GRID_X_DEF,
  parameter int GRID_Y = pga_pkg::GRID_Y_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [pga_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [pga_pkg::CFG_DATA_W-1:0]      cfg_data,
  pga_in_if.sink                                   in_if,
  pga_out_if.source                                out_if,
  input  pga_pkg::cmd_t                            cmd,
  output pga_pkg::sts_t                            sts
);

  localparam int NCELLS = GRID_X * GRID_Y;
  localparam int AW     = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int W      = pga_pkg::ACC_W;
  localparam logic [AW-1:0] LAST_CELL = AW'(NCELLS - 1);

  // configuration
  logic [63:0] n_win_r, m_win_r;
  logic [31:0] scale_x_r, scale_y_r, flux_scale_r, depth_scale_r;
  logic [15:0] nuc_cell_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_win_r       <= '0;
      m_win_r       <= '0;
      scale_x_r     <= pga_pkg::SCALE_ONE;
      scale_y_r     <= pga_pkg::SCALE_ONE;
      flux_scale_r  <= pga_pkg::SCALE_ONE;
      depth_scale_r <= pga_pkg::SCALE_ONE;
      nuc_cell_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pga_pkg::CFG_N_WINDOW:    n_win_r       <= cfg_data;
        pga_pkg::CFG_M_WINDOW:    m_win_r       <= cfg_data;
        pga_pkg::CFG_BIN_SCALE_X: scale_x_r     <= cfg_data[31:0];
        pga_pkg::CFG_BIN_SCALE_Y: scale_y_r     <= cfg_data[31:0];
        pga_pkg::CFG_FLUX_SCALE:  flux_scale_r  <= cfg_data[31:0];
        pga_pkg::CFG_DEPTH_SCALE: depth_scale_r <= cfg_data[31:0];
        pga_pkg::CFG_NUCLEUS:     nuc_cell_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // captured input word
  logic               in_acc;
  logic               op_r, em_r, last_r;
  logic signed [31:0] cn_r, cm_r;
  logic        [31:0] rad_r, wt_r;
  logic        [15:0] rc_r;

  assign in_if.ready = cmd.in_rdy;
  assign in_acc      = in_if.valid && cmd.in_rdy;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_if.operation;
      cn_r   <= in_if.coord_n;
      cm_r   <= in_if.coord_m;
      em_r   <= in_if.emitted;
      rad_r  <= in_if.radius;
      wt_r   <= in_if.weight;
      rc_r   <= in_if.read_cell;
      last_r <= in_if.last_particle;
    end
  end

  // window test and offsets
  logic signed [31:0] n_lo, n_hi, m_lo, m_hi;
  logic signed [32:0] dxs, dys;
  logic               win_ok;

  assign n_lo   = $signed(n_win_r[31:0]);
  assign n_hi   = $signed(n_win_r[63:32]);
  assign m_lo   = $signed(m_win_r[31:0]);
  assign m_hi   = $signed(m_win_r[63:32]);
  assign dxs    = {cn_r[31], cn_r} - {n_lo[31], n_lo};
  assign dys    = {cm_r[31], cm_r} - {m_lo[31], m_lo};
  assign win_ok = (cn_r >= n_lo) && (cn_r <= n_hi) && (cm_r >= m_lo) && (cm_r <= m_hi);

  // shared multiplier, product registered
  logic [31:0]  mul_a, mul_b;
  logic [63:0]  prod_r;
  logic [63:0]  r2_r, sw_r;
  logic [31:0]  ix_r, iy_r;

  always_comb begin
    case (cmd.mul_sel)
      pga_pkg::MUL_BINX: begin mul_a = dxs[31:0];     mul_b = scale_x_r;    end
      pga_pkg::MUL_BINY: begin mul_a = dys[31:0];     mul_b = scale_y_r;    end
      pga_pkg::MUL_RSQ:  begin mul_a = rad_r;         mul_b = rad_r;        end
      pga_pkg::MUL_FSW:  begin mul_a = flux_scale_r;  mul_b = wt_r;         end
      pga_pkg::MUL_DSW:  begin mul_a = depth_scale_r; mul_b = wt_r;         end
      pga_pkg::MUL_PP: begin
        mul_a = cmd.pp_step[1] ? r2_r[63:32] : r2_r[31:0];
        mul_b = cmd.pp_step[0] ? sw_r[63:32] : sw_r[31:0];
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= {32'd0, mul_a} * {32'd0, mul_b};
    if (cmd.ld_ix) ix_r <= prod_r[63:32];
    if (cmd.ld_iy) iy_r <= prod_r[63:32];
    if (cmd.ld_r2) r2_r <= prod_r;
    if (cmd.ld_sw) sw_r <= prod_r;
  end

  // partial product accumulation
  logic [127:0] acc_r, pp_sh;

  always_comb begin
    case (cmd.acc_step)
      2'd0:    pp_sh = {64'd0, prod_r};
      2'd3:    pp_sh = {prod_r, 64'd0};
      default: pp_sh = {32'd0, prod_r, 32'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_en) begin
      acc_r <= ((cmd.acc_step == 2'd0) ? 128'd0 : acc_r) + pp_sh;
    end
  end

  logic [W-1:0] fterm_r, dterm_r;

  always_ff @(posedge clk) begin
    if (cmd.ld_term) begin
      if (cmd.term_sel) begin
        dterm_r <= pga_pkg::sat_q(acc_r);
      end else begin
        fterm_r <= pga_pkg::sat_q(acc_r);
      end
    end
  end

  // cell select
  logic [31:0]   cell_calc, rc32, cell32;
  logic          bin_ok, rd_ok, chk_ok;
  logic [AW-1:0] cell_r;
  logic          ok_r;

  assign bin_ok    = (ix_r < 32'(GRID_X)) && (iy_r < 32'(GRID_Y));
  assign cell_calc = 32'(ix_r[10:0]) * 32'(GRID_Y) + 32'(iy_r[10:0]);
  assign rc32      = 32'(rc_r);
  assign rd_ok     = rc32 < 32'(NCELLS);
  assign chk_ok    = op_r ? rd_ok : (win_ok && bin_ok);
  assign cell32    = 32'(cell_r);

  always_ff @(posedge clk) begin
    if (cmd.ld_cell) begin
      cell_r <= op_r ? rc32[AW-1:0] : cell_calc[AW-1:0];
      ok_r   <= chk_ok;
    end
  end

  // grids, cleared by a sweep after reset
  logic [W-1:0]  flux_mem  [NCELLS];
  logic [W-1:0]  depth_mem [NCELLS];
  logic [W-1:0]  flux_rd_r, depth_rd_r;
  logic [W-1:0]  flux_new, depth_new;
  logic [AW-1:0] clr_cnt_r;
  logic [AW-1:0] waddr;
  logic          we;

  assign flux_new  = pga_pkg::sat_add(flux_rd_r, fterm_r);
  assign depth_new = pga_pkg::sat_add(depth_rd_r, dterm_r);
  assign we        = cmd.clr_en || cmd.wr_en;
  assign waddr     = cmd.clr_en ? clr_cnt_r : cell_r;

  always_ff @(posedge clk) begin
    if (we) begin
      flux_mem[waddr]  <= cmd.clr_en ? '0 : flux_new;
      depth_mem[waddr] <= cmd.clr_en ? '0 : depth_new;
    end
    flux_rd_r  <= flux_mem[cell_r];
    depth_rd_r <= depth_mem[cell_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  // nucleus total and updated cell values
  logic [W-1:0] nuc_r, res_flux_r, res_depth_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nuc_r <= '0;
    end else if (cmd.wr_en && em_r && (cell32 == 32'(nuc_cell_r))) begin
      nuc_r <= pga_pkg::sat_add(nuc_r, dterm_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      res_flux_r  <= flux_new;
      res_depth_r <= depth_new;
    end
  end

  // output register
  logic         out_valid_r;
  logic         o_acc_r, o_last_r;
  logic [15:0]  o_cell_r;
  logic [W-1:0] o_flux_r, o_depth_r, o_nuc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.ld_out) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      o_acc_r  <= ok_r;
      o_last_r <= last_r;
      o_nuc_r  <= nuc_r;
      if (op_r) begin
        o_cell_r  <= rc_r;
        o_flux_r  <= ok_r ? flux_rd_r : '0;
        o_depth_r <= ok_r ? depth_rd_r : '0;
      end else begin
        o_cell_r  <= ok_r ? cell32[15:0] : 16'd0;
        o_flux_r  <= ok_r ? res_flux_r : '0;
        o_depth_r <= ok_r ? res_depth_r : '0;
      end
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.accepted      = o_acc_r;
  assign out_if.cell_index    = o_cell_r;
  assign out_if.flux_value    = o_flux_r;
  assign out_if.depth_value   = o_depth_r;
  assign out_if.nucleus_depth = o_nuc_r;
  assign out_if.batch_done    = o_last_r;

  assign sts.in_acc   = in_acc;
  assign sts.is_read  = op_r;
  assign sts.chk_ok   = chk_ok;
  assign sts.clr_last = (clr_cnt_r == LAST_CELL);
  assign sts.out_free = !out_valid_r || out_if.ready;

`ifndef SYNTH
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.clr_en && cmd.in_rdy)) else $error("input taken during grid clear");
  a_write_only_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> (ok_r && !op_r)) else $error("grid write for rejected word");
  a_nuc_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> nuc_r >= $past(nuc_r)) else $error("nucleus total decreased");
  a_no_out_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_out |-> (!out_valid_r || out_if.ready)) else $error("result overwritten");
`endif

endmodule
`default_nettype wire
